// File: hdl/rie_pkg.sv
`timescale 1ns / 1ps

package rie_pkg;

	localparam int unsigned XLEN     = 32;
	localparam int unsigned REG_AW   = 5;
	localparam int unsigned REG_NUM  = 1 << REG_AW;

	// Primary opcodes.
	localparam logic [5:0] OP_RTYPE = 6'b000000;
	localparam logic [5:0] OP_ADDI  = 6'b001000;
	localparam logic [5:0] OP_ADDIU = 6'b001001;
	localparam logic [5:0] OP_SLTI  = 6'b001010;

	// Function codes of the register format.
	localparam logic [5:0] FN_MFHI = 6'b010000;
	localparam logic [5:0] FN_MFLO = 6'b010010;
	localparam logic [5:0] FN_MULT = 6'b011000;
	localparam logic [5:0] FN_DIV  = 6'b011010;
	localparam logic [5:0] FN_ADD  = 6'b100000;
	localparam logic [5:0] FN_ADDU = 6'b100001;
	localparam logic [5:0] FN_XOR  = 6'b100110;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;

endpackage

// File: hdl/risc_integer_execute_subset.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_ready   instruction_word
// output    out_valid / out_ready dest_index, dest_value, dest_written,
//                                 hi_value, lo_value, status
//
// add, addu, xor, mfhi, mflo, addi, addiu, slti, divide by zero and unsupported
// words are latched in IDLE, executed in PREP and wait in DONE for the output
// register. mult and div run a radix-2 shift register, one bit per cycle, over
// all 32 bits in ITER, then pass FIX and DONE. A new request is taken in the
// cycle after a result enters the output register, even before it is taken.
// Reset clears the register file valid bits, hi, lo, state, out_valid and cnt_q.

module risc_integer_execute_subset
	import rie_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                instruction_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [4:0]                 dest_index,
	output logic signed [31:0]         dest_value,
	output logic                       dest_written,
	output logic signed [31:0]         hi_value,
	output logic signed [31:0]         lo_value,
	output logic [1:0]                 status
);

	typedef enum logic [2:0] {IDLE, PREP, ITER, FIX, DONE} state_t;

	state_t              state_q;
	logic [XLEN-1:0]     instr_q;
	logic [XLEN-1:0]     rda_q, rdb_q;
	logic [REG_NUM-1:0]  valid_q;
	logic [XLEN-1:0]     hi_q, lo_q;
	logic [XLEN-1:0]     rf_mem [REG_NUM];

	logic [2*XLEN-1:0]   acc_q;
	logic [XLEN-1:0]     opb_q;
	logic [4:0]          cnt_q;
	logic                is_div_q, neg_q_q, neg_r_q;

	logic [REG_AW-1:0]   res_idx_q;
	logic [XLEN-1:0]     res_val_q, res_hi_q, res_lo_q;
	logic                res_wr_q;
	logic [1:0]          res_status_q;

	logic [5:0]          opc, fn;
	logic [REG_AW-1:0]   rs, rt, rd;
	logic [XLEN-1:0]     simm, op_a, op_b, mag_a, mag_b;
	logic                dec_wr, dec_mul, dec_div;
	logic [REG_AW-1:0]   dec_idx;
	logic [XLEN-1:0]     dec_val;
	logic [1:0]          dec_status;
	logic [XLEN:0]       mul_sum;
	logic [XLEN+1:0]     div_diff;
	logic [2*XLEN-1:0]   mul_next, div_next, prod_neg;
	logic [XLEN-1:0]     quo_fix, rem_fix;
	logic                commit;

	assign in_ready = (state_q == IDLE);
	assign commit   = (state_q == DONE) && (!out_valid || out_ready);

	assign opc  = instr_q[31:26];
	assign rs   = instr_q[25:21];
	assign rt   = instr_q[20:16];
	assign rd   = instr_q[15:11];
	assign fn   = instr_q[5:0];
	assign simm = {{(XLEN-16){instr_q[15]}}, instr_q[15:0]};

	// Entries never written, register 0 among them, read as zero.
	assign op_a  = valid_q[rs] ? rda_q : '0;
	assign op_b  = valid_q[rt] ? rdb_q : '0;
	assign mag_a = op_a[XLEN-1] ? (~op_a + 1'b1) : op_a;
	assign mag_b = op_b[XLEN-1] ? (~op_b + 1'b1) : op_b;

	always_comb begin
		dec_wr     = 1'b0;
		dec_mul    = 1'b0;
		dec_div    = 1'b0;
		dec_idx    = rd;
		dec_val    = '0;
		dec_status = ST_OK;
		unique case (opc) inside
			OP_RTYPE: begin
				unique case (fn) inside
					FN_ADD, FN_ADDU: begin
						dec_wr  = 1'b1;
						dec_val = op_a + op_b;
					end
					FN_XOR: begin
						dec_wr  = 1'b1;
						dec_val = op_a ^ op_b;
					end
					FN_MFHI: begin
						dec_wr  = 1'b1;
						dec_val = hi_q;
					end
					FN_MFLO: begin
						dec_wr  = 1'b1;
						dec_val = lo_q;
					end
					FN_MULT: dec_mul = 1'b1;
					FN_DIV: begin
						if (op_b == '0) begin
							dec_status = ST_DIVZ;
						end else begin
							dec_div = 1'b1;
						end
					end
					default: dec_status = ST_UNSUP;
				endcase
			end
			OP_ADDI, OP_ADDIU: begin
				dec_wr  = 1'b1;
				dec_idx = rt;
				dec_val = op_a + simm;
			end
			OP_SLTI: begin
				dec_wr  = 1'b1;
				dec_idx = rt;
				dec_val = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(simm))};
			end
			default: dec_status = ST_UNSUP;
		endcase
	end

	// Multiply: the multiplier sits in the low half and shifts out one bit
	// per cycle while the partial sum shifts in from the top.
	assign mul_sum  = {1'b0, acc_q[2*XLEN-1:XLEN]} + (acc_q[0] ? {1'b0, opb_q} : '0);
	assign mul_next = {mul_sum, acc_q[XLEN-1:1]};

	// Divide: restoring, with the remainder in the high half and the
	// quotient bits filling the low half.
	assign div_diff = {1'b0, acc_q[2*XLEN-1:XLEN-1]} - {2'b00, opb_q};
	assign div_next = div_diff[XLEN+1] ? {acc_q[2*XLEN-2:0], 1'b0}
	                                   : {div_diff[XLEN-1:0], acc_q[XLEN-2:0], 1'b1};

	assign prod_neg = neg_q_q ? (~acc_q + 1'b1) : acc_q;
	assign quo_fix  = neg_q_q ? (~acc_q[XLEN-1:0] + 1'b1) : acc_q[XLEN-1:0];
	assign rem_fix  = neg_r_q ? (~acc_q[2*XLEN-1:XLEN] + 1'b1) : acc_q[2*XLEN-1:XLEN];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rda_q <= rf_mem[instruction_word[25:21]];
			rdb_q <= rf_mem[instruction_word[20:16]];
		end
		if (commit && res_wr_q) begin
			rf_mem[res_idx_q] <= res_val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
			valid_q   <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			cnt_q     <= '0;
		end else begin
			if (out_valid && out_ready && !commit) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						instr_q <= instruction_word;
						state_q <= PREP;
					end
				end
				PREP: begin
					is_div_q <= dec_div;
					cnt_q    <= 5'd31;
					if (dec_mul) begin
						acc_q   <= {{XLEN{1'b0}}, mag_b};
						opb_q   <= mag_a;
						neg_q_q <= op_a[XLEN-1] ^ op_b[XLEN-1];
						state_q <= ITER;
					end else if (dec_div) begin
						acc_q   <= {{XLEN{1'b0}}, mag_a};
						opb_q   <= mag_b;
						neg_q_q <= op_a[XLEN-1] ^ op_b[XLEN-1];
						neg_r_q <= op_a[XLEN-1];
						state_q <= ITER;
					end else begin
						// A write to register 0 is reported as no write.
						if (dec_wr && (dec_idx != '0)) begin
							res_wr_q  <= 1'b1;
							res_idx_q <= dec_idx;
							res_val_q <= dec_val;
						end else begin
							res_wr_q  <= 1'b0;
							res_idx_q <= '0;
							res_val_q <= '0;
						end
						res_hi_q     <= hi_q;
						res_lo_q     <= lo_q;
						res_status_q <= dec_status;
						state_q      <= DONE;
					end
				end
				ITER: begin
					acc_q <= is_div_q ? div_next : mul_next;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= FIX;
					end
				end
				FIX: begin
					res_wr_q     <= 1'b0;
					res_idx_q    <= '0;
					res_val_q    <= '0;
					res_status_q <= ST_OK;
					if (is_div_q) begin
						res_hi_q <= rem_fix;
						res_lo_q <= quo_fix;
					end else begin
						res_hi_q <= prod_neg[2*XLEN-1:XLEN];
						res_lo_q <= prod_neg[XLEN-1:0];
					end
					state_q <= DONE;
				end
				DONE: begin
					if (commit) begin
						out_valid    <= 1'b1;
						dest_index   <= res_idx_q;
						dest_value   <= res_val_q;
						dest_written <= res_wr_q;
						hi_value     <= res_hi_q;
						lo_value     <= res_lo_q;
						status       <= res_status_q;
						hi_q         <= res_hi_q;
						lo_q         <= res_lo_q;
						if (res_wr_q) begin
							valid_q[res_idx_q] <= 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: hdl/rie_checker.sv
`timescale 1ns / 1ps

module rie_checker
	import rie_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [4:0]         dest_index,
	input logic signed [31:0] dest_value,
	input logic               dest_written,
	input logic signed [31:0] hi_value,
	input logic signed [31:0] lo_value,
	input logic [1:0]         status
);

	// A stalled result holds its index, value, hi, lo and status.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dest_value) && $stable(hi_value)
			&& $stable(lo_value) && $stable(status) && $stable(dest_index))
		else $error("stalled result changed");

	// Only an executed instruction may write a general register.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dest_written |-> status == ST_OK && dest_index != 5'd0)
		else $error("register write with bad status or index");

	// A result without a write carries zero index and value.
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dest_written |-> dest_index == 5'd0 && dest_value == 32'sd0)
		else $error("nonzero destination without a write");

	// Results never use the spare status code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_UNSUP || status == ST_DIVZ)
		else $error("undefined status code");

	// Only one request is in flight, so the input closes right after an accept.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

endmodule

bind risc_integer_execute_subset rie_checker u_rie_checker (.*);

// File: tb/risc_integer_execute_subset_test.sv
`timescale 1ns / 1ps

module risc_integer_execute_subset_test;
	import rie_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned TAIL_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES = 300;

	localparam logic [5:0] R_FUNCTS [7] = '{FN_ADD, FN_ADDU, FN_XOR, FN_MULT, FN_DIV,
		FN_MFHI, FN_MFLO};
	localparam logic [5:0] I_OPCODES [3] = '{OP_ADDI, OP_ADDIU, OP_SLTI};

	// Opcodes and function codes outside the subset, to provoke the unsupported status.
	localparam logic [5:0] OP_JUMP      = 6'b000010;
	localparam logic [5:0] OP_BEQ       = 6'b000100;
	localparam logic [5:0] OP_ALL_ONES  = 6'b111111;
	localparam logic [5:0] FN_SYSCALL   = 6'b001100;
	localparam logic [5:0] FN_SHIFT_LL  = 6'b000000;

	typedef struct {
		logic [4:0]  index;
		logic [31:0] value;
		logic        written;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [1:0]  status;
	} exec_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instruction_word;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  dest_index;
	logic signed [31:0] dest_value;
	logic        dest_written;
	logic signed [31:0] hi_value;
	logic signed [31:0] lo_value;
	logic [1:0]  status;

	logic [31:0] model_regs [32];
	logic [31:0] model_hi;
	logic [31:0] model_lo;
	exec_result_t expected_results [$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatch_count = 0;
	int unsigned cycle_count = 0;
	logic        hold_active = 1'b0;
	event        hold_off_start;

	risc_integer_execute_subset i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.dest_index       (dest_index),
		.dest_value       (dest_value),
		.dest_written     (dest_written),
		.hi_value         (hi_value),
		.lo_value         (lo_value),
		.status           (status)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
		input logic [4:0] rd, input logic [5:0] fn, input logic [4:0] shamt = 5'd0);
		return {OP_RTYPE, rs, rt, rd, shamt, fn};
	endfunction

	function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
		input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] read_model_reg(input logic [4:0] idx);
		return (idx == 5'd0) ? 32'd0 : model_regs[idx];
	endfunction

	// Executes one instruction on the shadow state and returns what the block must report.
	function automatic exec_result_t execute_word(input logic [31:0] w);
		exec_result_t res;
		logic [5:0]  opc;
		logic [5:0]  fn;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] simm;
		logic [31:0] mag_a;
		logic [31:0] mag_b;
		logic [31:0] quot;
		logic [31:0] rem;
		logic signed [63:0] wide_a;
		logic signed [63:0] wide_b;
		logic signed [63:0] product;
		logic        wr;
		opc = w[31:26];
		fn = w[5:0];
		rt = w[20:16];
		rd = w[15:11];
		a = read_model_reg(w[25:21]);
		b = read_model_reg(rt);
		simm = {{16{w[15]}}, w[15:0]};
		wr = 1'b0;
		res.index = 5'd0;
		res.value = 32'd0;
		res.status = ST_OK;
		if (opc == OP_RTYPE) begin
			case (fn)
				FN_ADD, FN_ADDU: begin
					wr = 1'b1; res.index = rd; res.value = a + b;
				end
				FN_XOR: begin
					wr = 1'b1; res.index = rd; res.value = a ^ b;
				end
				FN_MFHI: begin
					wr = 1'b1; res.index = rd; res.value = model_hi;
				end
				FN_MFLO: begin
					wr = 1'b1; res.index = rd; res.value = model_lo;
				end
				FN_MULT: begin
					wide_a = $signed(a);
					wide_b = $signed(b);
					product = wide_a * wide_b;
					model_hi = product[63:32];
					model_lo = product[31:0];
				end
				FN_DIV: begin
					if (b == 32'd0) begin
						res.status = ST_DIVZ;
					end else begin
						mag_a = a[31] ? -a : a;
						mag_b = b[31] ? -b : b;
						quot = mag_a / mag_b;
						rem = mag_a % mag_b;
						model_lo = (a[31] ^ b[31]) ? -quot : quot;
						model_hi = a[31] ? -rem : rem;
					end
				end
				default: res.status = ST_UNSUP;
			endcase
		end else if (opc == OP_ADDI || opc == OP_ADDIU) begin
			wr = 1'b1; res.index = rt; res.value = a + simm;
		end else if (opc == OP_SLTI) begin
			wr = 1'b1; res.index = rt;
			res.value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
		end else begin
			res.status = ST_UNSUP;
		end
		// A write to register 0 is dropped and reported as no write at all.
		if (wr && res.index != 5'd0) begin
			model_regs[res.index] = res.value;
		end else begin
			wr = 1'b0; res.index = 5'd0; res.value = 32'd0;
		end
		res.written = wr;
		res.hi = model_hi;
		res.lo = model_lo;
		return res;
	endfunction

	// Mostly well-formed instructions with random operands, some noise words.
	function automatic logic [31:0] random_word();
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [15:0] imm;
		int          pick;
		rs = 5'($urandom);
		rt = 5'($urandom);
		rd = 5'($urandom);
		imm = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom;
		if (pick < 15)
			return r_word(rs, rt, rd, 6'($urandom), 5'($urandom));
		if (pick < 65)
			return r_word(rs, rt, rd, R_FUNCTS[$urandom_range(6)], 5'($urandom));
		return i_word(I_OPCODES[$urandom_range(2)], rs, rt, imm);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: %s is %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_word(input logic [31:0] w);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			instruction_word <= $urandom;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		instruction_word <= w;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(execute_word(w));
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_word(i_word(OP_ADDIU, 5'd0, 5'd1, 16'h7fff));
		// The most negative immediate must come out sign-extended.
		send_word(i_word(OP_ADDI, 5'd0, 5'd2, 16'h8000));
		send_word(r_word(5'd1, 5'd2, 5'd3, FN_ADD));
		send_word(i_word(OP_ADDIU, 5'd0, 5'd4, 16'hffff));
		send_word(r_word(5'd2, 5'd2, 5'd0, FN_MULT));
		send_word(r_word(5'd0, 5'd0, 5'd5, FN_MFLO));
		send_word(r_word(5'd5, 5'd5, 5'd6, FN_ADDU));
		send_word(i_word(OP_ADDIU, 5'd6, 5'd7, 16'hffff));
		send_word(r_word(5'd7, 5'd7, 5'd8, FN_ADD));
		send_word(r_word(5'd6, 5'd4, 5'd9, FN_XOR));
		send_word(r_word(5'd6, 5'd6, 5'd0, FN_MULT));
		send_word(r_word(5'd7, 5'd7, 5'd0, FN_MULT));
		send_word(r_word(5'd6, 5'd4, 5'd0, FN_MULT));
		// Most negative value divided by minus one wraps the quotient.
		send_word(r_word(5'd6, 5'd4, 5'd0, FN_DIV));
		send_word(r_word(5'd2, 5'd1, 5'd0, FN_DIV));
		send_word(r_word(5'd1, 5'd0, 5'd0, FN_DIV));
		send_word(r_word(5'd0, 5'd0, 5'd10, FN_MFHI));
		send_word(i_word(OP_SLTI, 5'd4, 5'd11, 16'h0000));
		send_word(i_word(OP_SLTI, 5'd7, 5'd12, 16'h8000));
		send_word(i_word(OP_SLTI, 5'd6, 5'd13, 16'h7fff));
		send_word(r_word(5'd1, 5'd1, 5'd0, FN_ADD, 5'd31));
		send_word(i_word(OP_JUMP, 5'd31, 5'd31, 16'hffff));
		send_word(i_word(OP_BEQ, 5'd1, 5'd1, 16'h0001));
		send_word(r_word(5'd0, 5'd0, 5'd0, FN_SYSCALL));
		send_word(r_word(5'd0, 5'd0, 5'd0, FN_SHIFT_LL));
		send_word({OP_ALL_ONES, 26'h3ffffff});
		drain_results();
	endtask

	task automatic test_random(input int sender_pct, input int receiver_pct, input int count);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		repeat (count) send_word(random_word());
		drain_results();
	endtask

	// The receiver stops for a long stretch so the block fills and stalls its input.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		-> hold_off_start;
		repeat (30) send_word(random_word());
		drain_results();
	endtask

	initial forever begin
		@(hold_off_start);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_active <= 1'b0;
	end

	always @(negedge clk) begin
		if (hold_active)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result without request, dest_value", dest_value, 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (dest_index !== want.index)
					report_mismatch("dest_index", 32'(dest_index), 32'(want.index));
				if (dest_value !== want.value)
					report_mismatch("dest_value", dest_value, want.value);
				if (dest_written !== want.written)
					report_mismatch("dest_written", 32'(dest_written), 32'(want.written));
				if (hi_value !== want.hi)
					report_mismatch("hi_value", hi_value, want.hi);
				if (lo_value !== want.lo)
					report_mismatch("lo_value", lo_value, want.lo);
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		instruction_word = 32'd0;
		model_hi = 32'd0;
		model_lo = 32'd0;
		foreach (model_regs[i])
			model_regs[i] = 32'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(20, 79, 450);
		test_random(79, 20, 450);
		test_random(0, 0, 400);
		test_output_backpressure();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: filelist.f
hdl/rie_pkg.sv
hdl/risc_integer_execute_subset.sv
hdl/rie_checker.sv
tb/risc_integer_execute_subset_test.sv
